FILE: rtl/tea_block_cipher_defines.svh
`ifndef TEA_BLOCK_CIPHER_DEFINES_SVH
`define TEA_BLOCK_CIPHER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TEA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tea_block_cipher: check failed");

// Next-cycle implication, checked out of reset.
`define TEA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tea_block_cipher: check failed");

`endif

FILE: rtl/tea_pkg.sv
package tea_pkg;

    localparam int ROUNDS_DEF = 32;
    localparam logic [31:0] DELTA = 32'h9E37_79B9;

    localparam int WORD_W    = 32;
    localparam int NUM_KEYS  = 4;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] KEY_WORD0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] KEY_WORD1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] KEY_WORD2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] KEY_WORD3 = 3'd3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [NUM_KEYS-1:0][WORD_W-1:0] t_keys;

    // One item in flight through the round pipeline
    typedef struct packed {
        logic  valid;
        logic  dir;
        t_word y;
        t_word z;
    } t_stage;

    function automatic t_word mix_word(t_word x, t_word s, t_word ka, t_word kb);
        t_word hi;
        t_word lo;
        hi = (x << 4) + ka;
        lo = (x >> 5) + kb;
        return hi ^ (x + s) ^ lo;
    endfunction

endpackage

FILE: rtl/tea_stage.sv
// One half-round: updates one word of the block and registers the pair.
module tea_stage #(
    parameter int ROUNDS = tea_pkg::ROUNDS_DEF,
    parameter int STAGE  = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  tea_pkg::t_keys  i_keys,
    input  tea_pkg::t_stage i_stage,
    output tea_pkg::t_stage o_stage
);

    localparam int RND = STAGE / 2;
    localparam logic SECOND = 1'((STAGE % 2) == 1);
    localparam logic [63:0] PROD_ENC = 64'(tea_pkg::DELTA) * 64'(RND + 1);
    localparam logic [63:0] PROD_DEC = 64'(tea_pkg::DELTA) * 64'(ROUNDS - RND);
    localparam tea_pkg::t_word SUM_ENC = PROD_ENC[31:0];
    localparam tea_pkg::t_word SUM_DEC = PROD_DEC[31:0];

    tea_pkg::t_stage r_stage;
    tea_pkg::t_stage n_stage;

    logic           upd_y;
    tea_pkg::t_word src;
    tea_pkg::t_word tgt;
    tea_pkg::t_word sum;
    tea_pkg::t_word ka;
    tea_pkg::t_word kb;
    tea_pkg::t_word f;
    tea_pkg::t_word res;

    // encrypt: y then z; decrypt: z then y
    assign upd_y = (i_stage.dir == SECOND);
    assign src   = upd_y ? i_stage.z : i_stage.y;
    assign tgt   = upd_y ? i_stage.y : i_stage.z;
    assign ka    = upd_y ? i_keys[0] : i_keys[2];
    assign kb    = upd_y ? i_keys[1] : i_keys[3];
    assign sum   = i_stage.dir ? SUM_DEC : SUM_ENC;
    assign f     = tea_pkg::mix_word(src, sum, ka, kb);
    assign res   = i_stage.dir ? (tgt - f) : (tgt + f);

    always_comb begin
        n_stage       = i_stage;
        n_stage.y     = upd_y ? res : i_stage.y;
        n_stage.z     = upd_y ? i_stage.z : res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

FILE: rtl/tea_block_cipher.sv
// TEA encryption/decryption of 64-bit blocks under a 128-bit key held in four
// 32-bit registers. The rounds are fully unrolled into 2*ROUNDS register stages,
// one half-round each, so a new block can be taken every cycle while the output
// side keeps up; a result passes the stage registers, then the output register.
// A skid register behind the output register absorbs one result while the
// consumer stalls; the whole pipeline then holds until that result drains. Keys
// must be written only while no block is in flight; it is not enforced.
module tea_block_cipher #(
    parameter int ROUNDS = tea_pkg::ROUNDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tea_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tea_pkg::WORD_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [tea_pkg::WORD_W-1:0]    i_block_left,
    input  logic [tea_pkg::WORD_W-1:0]    i_block_right,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tea_pkg::WORD_W-1:0]    o_result_left,
    output logic [tea_pkg::WORD_W-1:0]    o_result_right
);

    localparam int NST = 2 * ROUNDS;

    tea_pkg::t_keys  r_keys;
    tea_pkg::t_stage pipe [0:NST];
    tea_pkg::t_stage r_out;
    tea_pkg::t_stage r_skid;
    logic            en;
    logic            out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tea_pkg::KEY_WORD0: r_keys[0] <= i_cfg_data;
                tea_pkg::KEY_WORD1: r_keys[1] <= i_cfg_data;
                tea_pkg::KEY_WORD2: r_keys[2] <= i_cfg_data;
                tea_pkg::KEY_WORD3: r_keys[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advances unless the skid register is holding a result
    assign en         = !r_skid.valid;
    assign o_in_ready = en;

    always_comb begin
        pipe[0].valid = i_in_valid;
        pipe[0].dir   = i_req_type;
        pipe[0].y     = i_block_left;
        pipe[0].z     = i_block_right;
    end

    for (genvar g = 0; g < NST; g++) begin : g_stage
        tea_stage #(
            .ROUNDS (ROUNDS),
            .STAGE  (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_keys  (r_keys),
            .i_stage (pipe[g]),
            .o_stage (pipe[g+1])
        );
    end

    assign out_free = !r_out.valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else if (r_skid.valid) begin
            if (i_out_ready) begin
                r_out        <= r_skid;
                r_skid.valid <= 1'b0;
            end
        end else if (pipe[NST].valid) begin
            if (out_free) begin
                r_out <= pipe[NST];
            end else begin
                r_skid <= pipe[NST];
            end
        end else if (i_out_ready) begin
            r_out.valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out.valid;
    assign o_result_left  = r_out.y;
    assign o_result_right = r_out.z;

endmodule

FILE: rtl/tea_checker.sv
`include "tea_block_cipher_defines.svh"

module tea_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_result_left,
    input logic [31:0] o_result_right
);

    // stalled result holds
    `TEA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_result_left) && $stable(o_result_right))

    // input side only backs up behind a held result
    `TEA_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready)

    `TEA_ASSERT_NOW(a_ready_fall, $fell(o_in_ready), $past(o_out_valid && !i_out_ready))

    // a backed-up pipeline stays held until the output is taken
    `TEA_ASSERT_NEXT(a_stall_holds, !o_in_ready && !i_out_ready, !o_in_ready)

endmodule

bind tea_block_cipher tea_checker u_tea_checker (.*);
